@@ rtl/arcre_pkg.sv @@
// shared types, constants and helpers for the adaptive replacement cache directory
package arcre_pkg;

    localparam int CAP_MAX = 1024;
    localparam int NENT    = 2 * CAP_MAX;
    localparam int IDX_W   = $clog2(NENT);
    localparam int CNT_W   = IDX_W + 1;
    localparam int BLK_W   = 48;
    localparam int CAP_W   = 11;

    localparam logic [1:0] REQ_WRITE = 2'd1;

    typedef enum logic [2:0] {
        LC_NONE = 3'd0,
        LC_T1   = 3'd1,
        LC_B1   = 3'd2,
        LC_T2   = 3'd3,
        LC_B2   = 3'd4
    } t_list_code;

    typedef enum logic [2:0] {
        CLS_HIT_T1   = 3'd0,
        CLS_HIT_T2   = 3'd1,
        CLS_GHOST_B1 = 3'd2,
        CLS_GHOST_B2 = 3'd3,
        CLS_MISS     = 3'd4
    } t_class;

    typedef enum logic [1:0] {
        OP_SCAN,
        OP_UNLINK,
        OP_POP,
        OP_PUSH
    } t_dir_op;

    typedef struct packed {
        logic [BLK_W-1:0] block;
        t_list_code       code;
        logic             dirty;
        logic [IDX_W-1:0] prev;
        logic [IDX_W-1:0] next;
    } t_entry;

    typedef struct packed {
        t_dir_op          op;
        logic [IDX_W-1:0] e;
        t_list_code       code;
        logic             dset;
        logic             dval;
        logic             setblk;
        logic             newhwm;
    } t_dir_cmd;

    typedef struct packed {
        logic             hit;
        t_list_code       hit_code;
        logic [IDX_W-1:0] hit_e;
        logic             free_v;
        logic [IDX_W-1:0] free_e;
        logic             pop_v;
        logic [IDX_W-1:0] pop_e;
        logic             wb_v;
        logic [BLK_W-1:0] wb_blk;
    } t_dir_rsp;

    // list code to list slot: T1 0, B1 1, T2 2, B2 3
    function automatic logic [1:0] lidx(input t_list_code c);
        logic [2:0] t;
        t = c - 3'd1;
        return t[1:0];
    endfunction

endpackage

@@ rtl/arcre_div.sv @@
// restoring divider, one quotient bit per cycle, for the ghost size ratio
module arcre_div import arcre_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [CNT_W-1:0] i_num,
    input  logic [CNT_W-1:0] i_den,
    output logic             o_done,
    output logic [CNT_W-1:0] o_quo
);

    localparam int CW = $clog2(CNT_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [CW-1:0]    r_cnt;
    logic [CNT_W:0]   r_rem;
    logic [CNT_W-1:0] r_quo;
    logic [CNT_W-1:0] r_den;
    logic [CNT_W:0]   trial;
    logic             bit_q;

    assign trial = {r_rem[CNT_W-1:0], r_quo[CNT_W-1]};
    assign bit_q = trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(CNT_W);
                r_rem  <= '0;
                r_quo  <= i_num;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= bit_q ? (trial - {1'b0, r_den}) : trial;
                r_quo <= {r_quo[CNT_W-2:0], bit_q};
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

@@ rtl/arcre_dir.sv @@
// directory memory with linked-list head/tail/size and the list operations
module arcre_dir import arcre_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_flush,
    input  logic                        i_cmd_v,
    input  t_dir_cmd                    i_cmd,
    input  logic [BLK_W-1:0]            i_blk,
    output logic                        o_done,
    output t_dir_rsp                    o_rsp,
    output logic [3:0][CNT_W-1:0]       o_size,
    output logic [CNT_W-1:0]            o_hwm
);

    typedef enum logic [2:0] {
        D_IDLE, D_SCAN, D_E_RD, D_E_WR, D_NB_RD, D_NB_WR, D_DONE
    } t_dstate;

    t_entry           mem [NENT];
    t_entry           r_rdata;

    t_dstate          r_state;
    t_dir_cmd         r_cmd;
    t_dir_rsp         r_rsp;
    logic [CNT_W-1:0] r_idx;
    logic             r_chk_v;
    logic [IDX_W-1:0] r_chk_idx;
    logic [IDX_W-1:0] r_head [4];
    logic [IDX_W-1:0] r_tail [4];
    logic [CNT_W-1:0] r_size [4];
    logic [CNT_W-1:0] r_hwm;
    logic [1:0]       r_npend;
    logic [IDX_W-1:0] r_na [2];
    logic             r_nf [2];
    logic [IDX_W-1:0] r_nv [2];

    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             we;
    logic [IDX_W-1:0] wr_addr;
    t_entry           wr_data;
    logic             nsel;
    logic             scan_issue;
    t_dir_cmd         cmd_in;

    // entry update step
    logic             is_push;
    logic             code_ok;
    logic [1:0]       e_l;
    t_entry           e_word;
    logic             e_wr;
    logic             p0, p1;
    logic [IDX_W-1:0] a0, a1, v0, v1;
    logic             f0, f1;
    t_entry           nb_word;

    assign nsel       = ~r_npend[0];
    assign scan_issue = (r_state == D_SCAN) && (r_idx < r_hwm);
    assign is_push    = (r_cmd.op == OP_PUSH);
    assign code_ok    = (r_rdata.code >= LC_T1) && (r_rdata.code <= LC_B2);

    // a pop works on the tail entry of its list
    always_comb begin
        cmd_in = i_cmd;
        if (i_cmd.op == OP_POP) cmd_in.e = r_tail[lidx(i_cmd.code)];
    end

    always_comb begin
        e_l    = is_push ? lidx(r_cmd.code) : lidx(r_rdata.code);
        e_word = r_rdata;
        e_wr   = 1'b0;
        p0     = 1'b0;
        p1     = 1'b0;
        a0     = '0;
        a1     = '0;
        v0     = '0;
        v1     = '0;
        f0     = 1'b0;
        f1     = 1'b0;
        if (is_push) begin
            e_wr        = 1'b1;
            e_word.code = r_cmd.code;
            if (r_size[e_l] != '0) begin
                e_word.next = r_head[e_l];
                p0 = 1'b1;
                a0 = r_head[e_l];
                f0 = 1'b0;
                v0 = r_cmd.e;
            end
            if (r_cmd.dset) e_word.dirty = r_cmd.dval;
            if (r_cmd.setblk) e_word.block = i_blk;
        end else if (code_ok) begin
            e_wr        = 1'b1;
            e_word.code = LC_NONE;
            if (r_cmd.op == OP_POP) e_word.dirty = 1'b0;
            if (r_head[e_l] != r_cmd.e) begin
                p0 = 1'b1;
                a0 = r_rdata.prev;
                f0 = 1'b1;
                v0 = r_rdata.next;
            end
            if (r_tail[e_l] != r_cmd.e) begin
                p1 = 1'b1;
                a1 = r_rdata.next;
                f1 = 1'b0;
                v1 = r_rdata.prev;
            end
        end
    end

    always_comb begin
        nb_word = r_rdata;
        if (r_nf[nsel]) nb_word.next = r_nv[nsel];
        else            nb_word.prev = r_nv[nsel];
    end

    always_comb begin
        rd_en   = scan_issue || (r_state == D_E_RD) || (r_state == D_NB_RD);
        rd_addr = r_na[nsel];
        if (r_state == D_SCAN) rd_addr = r_idx[IDX_W-1:0];
        else if (r_state == D_E_RD) rd_addr = r_cmd.e;
        we      = ((r_state == D_E_WR) && e_wr) || (r_state == D_NB_WR);
        wr_addr = (r_state == D_E_WR) ? r_cmd.e : r_na[nsel];
        wr_data = (r_state == D_E_WR) ? e_word : nb_word;
    end

    always_ff @(posedge i_clk) begin
        if (we) mem[wr_addr] <= wr_data;
        if (rd_en) r_rdata <= mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_flush) begin
            r_state <= D_IDLE;
            r_hwm   <= '0;
            r_npend <= '0;
            r_chk_v <= 1'b0;
            r_rsp   <= '0;
            for (int i = 0; i < 4; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_size[i] <= '0;
            end
        end else begin
            unique case (r_state)
                D_IDLE: begin
                    if (i_cmd_v) begin
                        r_cmd <= cmd_in;
                        unique case (i_cmd.op)
                            OP_SCAN: begin
                                r_idx        <= '0;
                                r_chk_v      <= 1'b0;
                                r_rsp.hit    <= 1'b0;
                                r_rsp.free_v <= 1'b0;
                                r_state      <= D_SCAN;
                            end
                            OP_UNLINK, OP_PUSH: r_state <= D_E_RD;
                            OP_POP: begin
                                r_rsp.wb_v <= 1'b0;
                                if (r_size[lidx(i_cmd.code)] == '0) begin
                                    r_rsp.pop_v <= 1'b0;
                                    r_state     <= D_DONE;
                                end else begin
                                    r_rsp.pop_v <= 1'b1;
                                    r_rsp.pop_e <= r_tail[lidx(i_cmd.code)];
                                    r_state     <= D_E_RD;
                                end
                            end
                        endcase
                    end
                end
                D_SCAN: begin
                    if (scan_issue) r_idx <= r_idx + 1'b1;
                    r_chk_v   <= scan_issue;
                    r_chk_idx <= r_idx[IDX_W-1:0];
                    if (!r_chk_v && !scan_issue) r_state <= D_DONE;
                    if (r_chk_v && r_rdata.code == LC_NONE && !r_rsp.free_v) begin
                        r_rsp.free_v <= 1'b1;
                        r_rsp.free_e <= r_chk_idx;
                    end
                    if (r_chk_v && r_rdata.code != LC_NONE && r_rdata.block == i_blk) begin
                        r_rsp.hit      <= 1'b1;
                        r_rsp.hit_e    <= r_chk_idx;
                        r_rsp.hit_code <= r_rdata.code;
                        r_state        <= D_DONE;
                    end
                end
                D_E_RD: r_state <= D_E_WR;
                D_E_WR: begin
                    if (is_push) begin
                        if (r_size[e_l] == '0) r_tail[e_l] <= r_cmd.e;
                        r_head[e_l] <= r_cmd.e;
                        r_size[e_l] <= r_size[e_l] + 1'b1;
                        if (r_cmd.newhwm) r_hwm <= r_hwm + 1'b1;
                    end else if (code_ok) begin
                        if (r_head[e_l] == r_cmd.e) r_head[e_l] <= r_rdata.next;
                        if (r_tail[e_l] == r_cmd.e) r_tail[e_l] <= r_rdata.prev;
                        r_size[e_l] <= r_size[e_l] - 1'b1;
                        if (r_cmd.op == OP_POP && r_rdata.dirty
                            && (r_rdata.code == LC_T1 || r_rdata.code == LC_T2)) begin
                            r_rsp.wb_v   <= 1'b1;
                            r_rsp.wb_blk <= r_rdata.block;
                        end
                    end
                    r_npend <= {p1, p0};
                    r_na[0] <= a0;
                    r_na[1] <= a1;
                    r_nf[0] <= f0;
                    r_nf[1] <= f1;
                    r_nv[0] <= v0;
                    r_nv[1] <= v1;
                    r_state <= (p0 || p1) ? D_NB_RD : D_DONE;
                end
                D_NB_RD: r_state <= D_NB_WR;
                D_NB_WR: begin
                    if (nsel) begin
                        r_npend[1] <= 1'b0;
                        r_state    <= D_DONE;
                    end else begin
                        r_npend[0] <= 1'b0;
                        r_state    <= r_npend[1] ? D_NB_RD : D_DONE;
                    end
                end
                D_DONE: r_state <= D_IDLE;
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_done = (r_state == D_DONE);
    assign o_rsp  = r_rsp;
    assign o_hwm  = r_hwm;
    always_comb begin
        for (int i = 0; i < 4; i++) o_size[i] = r_size[i];
    end

endmodule

@@ rtl/arc_replacement_engine.sv @@
// adaptive replacement cache directory: top level sequencer and result register
// One request at a time. The directory lives in a single memory with one read and one
// write port; lookup scans the entries allocated since the last flush, one per cycle,
// and stops at the first hit. A ghost hit whose adaptation step needs a ratio adds a
// divide. A write to the capacity register flushes all lists and the target p at
// once; no clearing pass is needed. The next request is taken while a finished
// result still waits.
module arc_replacement_engine import arcre_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [CAP_W-1:0] i_cfg_cache_capacity,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  logic [BLK_W-1:0] i_block_addr,
    input  logic [1:0]       i_req_type,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [2:0]       o_access_class,
    output logic             o_needs_fetch,
    output logic             o_writeback_valid,
    output logic [BLK_W-1:0] o_writeback_block,
    output logic [CAP_W-1:0] o_target_p
);

    typedef enum logic [3:0] {
        T_IDLE, T_SCAN, T_CLASS, T_DIV, T_UNLINK, T_REPL, T_REPL_POP,
        T_REPL_PUSH, T_MISS_POP, T_ALLOC, T_PUSH_FIN, T_OUT
    } t_state;

    t_state           r_state;
    logic             r_wait;
    logic [BLK_W-1:0] r_blk;
    logic             r_write;
    t_class           r_cls;
    logic [IDX_W-1:0] r_e;
    logic             r_free_v;
    logic [IDX_W-1:0] r_free_e;
    logic             r_freed_v;
    logic [IDX_W-1:0] r_freed_e;
    t_list_code       r_src;
    logic [IDX_W-1:0] r_rep_e;
    t_list_code       r_mpop_code;
    logic             r_mpop_repl;
    logic [CAP_W-1:0] r_p;
    logic [CAP_W-1:0] r_cap;
    logic             r_wb_v;
    logic [BLK_W-1:0] r_wb_blk;
    logic             r_o_valid;
    t_class           r_o_cls;
    logic             r_o_fetch;
    logic             r_o_wb_v;
    logic [BLK_W-1:0] r_o_wb_blk;
    logic [CAP_W-1:0] r_o_p;

    logic                  cmd_v;
    t_dir_cmd              cmd;
    logic                  dir_done;
    t_dir_rsp              rsp;
    logic [3:0][CNT_W-1:0] size;
    logic [CNT_W-1:0]      hwm;
    logic                  div_start;
    logic [CNT_W-1:0]      div_num;
    logic [CNT_W-1:0]      div_den;
    logic                  div_done;
    logic [CNT_W-1:0]      div_quo;

    logic [CAP_W-1:0] c_eff;
    logic [CNT_W-1:0] t1, b1, t2, b2;
    logic [CNT_W:0]   t1b1;
    logic [CNT_W+1:0] sum4;
    logic [CNT_W-1:0] hs, os;
    logic             ghost;
    logic             hwm_free;
    logic             alloc_ok;
    logic [IDX_W-1:0] alloc_e;
    logic             from_b2;
    t_list_code       src_a;
    t_list_code       src_b;
    logic             src_ok;
    logic             out_free;

    assign c_eff = (r_cap == '0) ? CAP_W'(1)
                 : (r_cap > CAP_W'(CAP_MAX)) ? CAP_W'(CAP_MAX) : r_cap;
    assign t1    = size[lidx(LC_T1)];
    assign b1    = size[lidx(LC_B1)];
    assign t2    = size[lidx(LC_T2)];
    assign b2    = size[lidx(LC_B2)];
    assign t1b1  = {1'b0, t1} + {1'b0, b1};
    assign sum4  = {2'b0, t1} + {2'b0, b1} + {2'b0, t2} + {2'b0, b2};
    assign ghost = (r_cls == CLS_GHOST_B1) || (r_cls == CLS_GHOST_B2);

    // adaptation: sizes of the hit ghost list and the other one
    assign hs = (rsp.hit_code == LC_B1) ? b1 : b2;
    assign os = (rsp.hit_code == LC_B1) ? b2 : b1;

    function automatic logic [CAP_W-1:0] adapt_p(input logic [CAP_W-1:0] p,
                                                 input logic [CNT_W-1:0] d,
                                                 input logic up,
                                                 input logic [CAP_W-1:0] c);
        logic [CNT_W:0] s;
        s = {2'b0, p} + {1'b0, d};
        if (up) return (s >= {2'b0, c}) ? c : s[CAP_W-1:0];
        return ({1'b0, d} >= {2'b0, p}) ? '0 : CAP_W'(p - d[CAP_W-1:0]);
    endfunction

    // victim list for one replacement
    assign from_b2 = (r_cls == CLS_GHOST_B2);
    always_comb begin
        if (t1 != '0 && (t1 > {1'b0, r_p} || (from_b2 && t1 == {1'b0, r_p})))
            src_a = LC_T1;
        else
            src_a = LC_T2;
        src_b = src_a;
        if (size[lidx(src_a)] == '0) src_b = (src_a == LC_T1) ? LC_T2 : LC_T1;
        src_ok = (size[lidx(src_b)] != '0);
    end

    assign hwm_free = (hwm < CNT_W'(NENT));
    assign alloc_ok = r_free_v || hwm_free || r_freed_v;
    assign alloc_e  = r_free_v ? r_free_e : hwm_free ? hwm[IDX_W-1:0] : r_freed_e;

    always_comb begin
        cmd   = '0;
        cmd_v = 1'b0;
        unique case (r_state)
            T_SCAN: begin
                cmd.op = OP_SCAN;
                cmd_v  = !r_wait;
            end
            T_UNLINK: begin
                cmd.op = OP_UNLINK;
                cmd.e  = r_e;
                cmd_v  = !r_wait;
            end
            T_REPL_POP: begin
                cmd.op   = OP_POP;
                cmd.code = r_src;
                cmd_v    = !r_wait;
            end
            T_REPL_PUSH: begin
                cmd.op   = OP_PUSH;
                cmd.e    = r_rep_e;
                cmd.code = (r_src == LC_T1) ? LC_B1 : LC_B2;
                cmd_v    = !r_wait;
            end
            T_MISS_POP: begin
                cmd.op   = OP_POP;
                cmd.code = r_mpop_code;
                cmd_v    = !r_wait;
            end
            T_ALLOC: begin
                cmd.op     = OP_PUSH;
                cmd.e      = alloc_e;
                cmd.code   = LC_T1;
                cmd.dset   = 1'b1;
                cmd.dval   = r_write;
                cmd.setblk = 1'b1;
                cmd.newhwm = !r_free_v && hwm_free;
                cmd_v      = alloc_ok && !r_wait;
            end
            T_PUSH_FIN: begin
                cmd.op   = OP_PUSH;
                cmd.e    = r_e;
                cmd.code = LC_T2;
                cmd.dset = ghost || r_write;
                cmd.dval = r_write;
                cmd_v    = !r_wait;
            end
            default: begin
                cmd_v = 1'b0;
            end
        endcase
    end

    assign div_start = (r_state == T_CLASS) && rsp.hit
                    && (rsp.hit_code == LC_B1 || rsp.hit_code == LC_B2)
                    && !(hs >= os || hs == '0);
    assign div_num   = os;
    assign div_den   = hs;
    assign out_free  = !r_o_valid || !i_out_stall;

    arcre_dir u_dir (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flush (i_cfg_we),
        .i_cmd_v (cmd_v),
        .i_cmd   (cmd),
        .i_blk   (r_blk),
        .o_done  (dir_done),
        .o_rsp   (rsp),
        .o_size  (size),
        .o_hwm   (hwm)
    );

    arcre_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= T_IDLE;
            r_wait    <= 1'b0;
            r_p       <= '0;
            r_cap     <= CAP_W'(CAP_MAX);
            r_o_valid <= 1'b0;
        end else begin
            if (cmd_v) r_wait <= 1'b1;
            if (dir_done) r_wait <= 1'b0;
            if (r_state == T_OUT && out_free) r_o_valid <= 1'b1;
            else if (r_o_valid && !i_out_stall) r_o_valid <= 1'b0;
            if (i_cfg_we) begin
                r_cap <= i_cfg_cache_capacity;
                r_p   <= '0;
            end
            unique case (r_state)
                T_IDLE: begin
                    if (i_in_valid) begin
                        r_blk     <= i_block_addr;
                        r_write   <= (i_req_type == REQ_WRITE);
                        r_wb_v    <= 1'b0;
                        r_freed_v <= 1'b0;
                        r_state   <= T_SCAN;
                    end
                end
                T_SCAN: begin
                    if (dir_done) begin
                        r_e      <= rsp.hit_e;
                        r_free_v <= rsp.free_v;
                        r_free_e <= rsp.free_e;
                        r_state  <= T_CLASS;
                    end
                end
                T_CLASS: begin
                    if (rsp.hit) begin
                        unique case (rsp.hit_code)
                            LC_T1: begin
                                r_cls   <= CLS_HIT_T1;
                                r_state <= T_UNLINK;
                            end
                            LC_T2: begin
                                r_cls   <= CLS_HIT_T2;
                                r_state <= T_UNLINK;
                            end
                            LC_B1, LC_B2: begin
                                r_cls <= (rsp.hit_code == LC_B1) ? CLS_GHOST_B1
                                                                 : CLS_GHOST_B2;
                                if (div_start) begin
                                    r_state <= T_DIV;
                                end else begin
                                    r_p     <= adapt_p(r_p, CNT_W'(1),
                                                       rsp.hit_code == LC_B1, c_eff);
                                    r_state <= T_UNLINK;
                                end
                            end
                            default: r_state <= T_UNLINK;
                        endcase
                    end else begin
                        r_cls <= CLS_MISS;
                        if (t1b1 >= {2'b0, c_eff}) begin
                            // B1 ghost dropped, or T1 LRU discarded when T1 is full
                            r_mpop_code <= (t1 < {1'b0, c_eff}) ? LC_B1 : LC_T1;
                            r_mpop_repl <= (t1 < {1'b0, c_eff});
                            r_state     <= T_MISS_POP;
                        end else if (sum4 >= {3'b0, c_eff}) begin
                            if (sum4 >= {2'b0, c_eff, 1'b0}) begin
                                r_mpop_code <= LC_B2;
                                r_mpop_repl <= 1'b1;
                                r_state     <= T_MISS_POP;
                            end else begin
                                r_state <= T_REPL;
                            end
                        end else begin
                            r_state <= T_ALLOC;
                        end
                    end
                end
                T_DIV: begin
                    if (div_done) begin
                        r_p     <= adapt_p(r_p, div_quo, r_cls == CLS_GHOST_B1, c_eff);
                        r_state <= T_UNLINK;
                    end
                end
                T_UNLINK: begin
                    if (dir_done) r_state <= ghost ? T_REPL : T_PUSH_FIN;
                end
                T_REPL: begin
                    if (src_ok) begin
                        r_src   <= src_b;
                        r_state <= T_REPL_POP;
                    end else begin
                        r_state <= ghost ? T_PUSH_FIN : T_ALLOC;
                    end
                end
                T_REPL_POP: begin
                    if (dir_done) begin
                        r_rep_e <= rsp.pop_e;
                        if (rsp.wb_v) begin
                            r_wb_v   <= 1'b1;
                            r_wb_blk <= rsp.wb_blk;
                        end
                        r_state <= T_REPL_PUSH;
                    end
                end
                T_REPL_PUSH: begin
                    if (dir_done) r_state <= ghost ? T_PUSH_FIN : T_ALLOC;
                end
                T_MISS_POP: begin
                    if (dir_done) begin
                        if (rsp.pop_v) begin
                            r_freed_v <= 1'b1;
                            r_freed_e <= rsp.pop_e;
                        end
                        if (rsp.wb_v) begin
                            r_wb_v   <= 1'b1;
                            r_wb_blk <= rsp.wb_blk;
                        end
                        r_state <= r_mpop_repl ? T_REPL : T_ALLOC;
                    end
                end
                T_ALLOC: begin
                    // no room at all: reported as a miss without insertion
                    if (!alloc_ok || dir_done) r_state <= T_OUT;
                end
                T_PUSH_FIN: begin
                    if (dir_done) r_state <= T_OUT;
                end
                T_OUT: begin
                    if (out_free) begin
                        r_o_cls    <= r_cls;
                        r_o_fetch  <= (r_cls != CLS_HIT_T1) && (r_cls != CLS_HIT_T2);
                        r_o_wb_v   <= r_wb_v;
                        r_o_wb_blk <= r_wb_v ? r_wb_blk : '0;
                        r_o_p      <= r_p;
                        r_state    <= T_IDLE;
                    end
                end
                default: r_state <= T_IDLE;
            endcase
        end
    end

    assign o_in_stall        = (r_state != T_IDLE);
    assign o_out_valid       = r_o_valid;
    assign o_access_class    = r_o_cls;
    assign o_needs_fetch     = r_o_fetch;
    assign o_writeback_valid = r_o_wb_v;
    assign o_writeback_block = r_o_wb_blk;
    assign o_target_p        = r_o_p;

    a_p_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p <= c_eff)
        else $error("target p above capacity");

    a_fetch_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_needs_fetch |->
            o_access_class == CLS_HIT_T1 || o_access_class == CLS_HIT_T2)
        else $error("no fetch on a non-hit request");

    a_dir_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dir_done |-> r_wait)
        else $error("directory completion without an issued command");

    a_wb_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_writeback_valid |-> o_writeback_block == '0)
        else $error("writeback block set without writeback");

endmodule

@@ bench/testbench.sv @@
// self-checking testbench for the adaptive replacement cache directory
module testbench import arcre_pkg::*;;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 6000000;

    typedef struct {
        t_class           cls;
        logic             fetch;
        logic             wb_v;
        logic [BLK_W-1:0] wb_blk;
        logic [CAP_W-1:0] tgt;
    } t_access_result;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CAP_W-1:0] i_cfg_cache_capacity;
    logic             i_in_valid;
    logic             o_in_stall;
    logic [BLK_W-1:0] i_block_addr;
    logic [1:0]       i_req_type;
    logic             o_out_valid;
    logic             i_out_stall;
    logic [2:0]       o_access_class;
    logic             o_needs_fetch;
    logic             o_writeback_valid;
    logic [BLK_W-1:0] o_writeback_block;
    logic [CAP_W-1:0] o_target_p;

    arc_replacement_engine DUT (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_we             (i_cfg_we),
        .i_cfg_cache_capacity (i_cfg_cache_capacity),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_block_addr         (i_block_addr),
        .i_req_type           (i_req_type),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_access_class       (o_access_class),
        .o_needs_fetch        (o_needs_fetch),
        .o_writeback_valid    (o_writeback_valid),
        .o_writeback_block    (o_writeback_block),
        .o_target_p           (o_target_p)
    );

    // directory shadow
    logic [BLK_W-1:0] dir_blk   [NENT];
    t_list_code       dir_code  [NENT];
    bit               dir_dirty [NENT];
    int               dir_prev  [NENT];
    int               dir_next  [NENT];
    int               lst_head  [4];
    int               lst_tail  [4];
    int               lst_size  [4];
    int               target_p;
    int               cap_reg;
    bit               wb_seen;
    logic [BLK_W-1:0] wb_addr;

    t_access_result   pending_results[$];
    int               mismatches;
    int               cycles = 0;
    int               src_idle_pct;
    int               dst_idle_pct;
    int               hold_cycles;
    logic [BLK_W-1:0] addr_pool[$];

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random stall, or a long hold-off counted here
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            i_out_stall = 1'b1;
            hold_cycles = hold_cycles - 1;
        end else begin
            i_out_stall = ($urandom_range(99) < dst_idle_pct);
        end
    end

    function automatic int eff_cap();
        if (cap_reg < 1) return 1;
        if (cap_reg > CAP_MAX) return CAP_MAX;
        return cap_reg;
    endfunction

    function automatic int slot_of(t_list_code c);
        return int'(c) - 1;
    endfunction

    function automatic void flush_directory();
        for (int i = 0; i < NENT; i++) begin
            dir_blk[i] = '1;
            dir_code[i] = LC_NONE;
            dir_dirty[i] = 0;
        end
        for (int i = 0; i < 4; i++) begin
            lst_head[i] = 0;
            lst_tail[i] = 0;
            lst_size[i] = 0;
        end
        target_p = 0;
    endfunction

    function automatic void list_unlink(int e);
        int l;
        int pv;
        int nx;
        if (dir_code[e] == LC_NONE) return;
        l = slot_of(dir_code[e]);
        pv = dir_prev[e];
        nx = dir_next[e];
        if (lst_head[l] == e) lst_head[l] = nx;
        else dir_next[pv] = nx;
        if (lst_tail[l] == e) lst_tail[l] = pv;
        else dir_prev[nx] = pv;
        lst_size[l]--;
        dir_code[e] = LC_NONE;
    endfunction

    function automatic void list_push_mru(int e, t_list_code c);
        int l;
        l = slot_of(c);
        if (lst_size[l] == 0) begin
            lst_tail[l] = e;
        end else begin
            dir_next[e] = lst_head[l];
            dir_prev[lst_head[l]] = e;
        end
        lst_head[l] = e;
        lst_size[l]++;
        dir_code[e] = c;
    endfunction

    function automatic void release_entry(int e);
        dir_blk[e] = '1;
        dir_code[e] = LC_NONE;
        dir_dirty[e] = 0;
    endfunction

    function automatic int list_pop_lru(t_list_code c);
        int e;
        if (lst_size[slot_of(c)] == 0) return -1;
        e = lst_tail[slot_of(c)];
        list_unlink(e);
        if ((c == LC_T1 || c == LC_T2) && dir_dirty[e]) begin
            wb_seen = 1;
            wb_addr = dir_blk[e];
            dir_dirty[e] = 0;
        end
        return e;
    endfunction

    function automatic void evict_to_ghost(bit from_b2);
        int t1;
        int e;
        t_list_code src;
        t1 = lst_size[slot_of(LC_T1)];
        if (t1 > 0 && (t1 > target_p || (from_b2 && t1 == target_p))) src = LC_T1;
        else src = LC_T2;
        if (lst_size[slot_of(src)] == 0) src = (src == LC_T1) ? LC_T2 : LC_T1;
        if (lst_size[slot_of(src)] == 0) return;
        e = list_pop_lru(src);
        list_push_mru(e, (src == LC_T1) ? LC_B1 : LC_B2);
    endfunction

    function automatic void adapt_target(t_list_code c);
        int b1;
        int b2;
        int d;
        b1 = lst_size[slot_of(LC_B1)];
        b2 = lst_size[slot_of(LC_B2)];
        if (c == LC_B1) begin
            d = (b1 >= b2 || b1 == 0) ? 1 : b2 / b1;
            target_p = (target_p + d >= eff_cap()) ? eff_cap() : target_p + d;
        end else begin
            d = (b2 >= b1 || b2 == 0) ? 1 : b1 / b2;
            target_p = (d >= target_p) ? 0 : target_p - d;
        end
    endfunction

    function automatic t_access_result predict_access(logic [BLK_W-1:0] blk, logic [1:0] rt);
        t_access_result r;
        int e;
        int v;
        int t1;
        int b1;
        int t2;
        int b2;
        int c;
        t_list_code code;
        c = eff_cap();
        e = -1;
        wb_seen = 0;
        wb_addr = '0;
        for (int i = 0; i < NENT; i++) begin
            if (dir_code[i] != LC_NONE && dir_blk[i] == blk) begin
                e = i;
                break;
            end
        end
        r.fetch = 1'b1;
        if (e >= 0) begin
            code = dir_code[e];
            if (code == LC_T1 || code == LC_T2) begin
                r.cls = (code == LC_T1) ? CLS_HIT_T1 : CLS_HIT_T2;
                r.fetch = 1'b0;
                list_unlink(e);
                list_push_mru(e, LC_T2);
                if (rt == REQ_WRITE) dir_dirty[e] = 1;
            end else begin
                r.cls = (code == LC_B1) ? CLS_GHOST_B1 : CLS_GHOST_B2;
                adapt_target(code);
                list_unlink(e);
                evict_to_ghost(code == LC_B2);
                dir_dirty[e] = (rt == REQ_WRITE);
                list_push_mru(e, LC_T2);
            end
        end else begin
            r.cls = CLS_MISS;
            t1 = lst_size[slot_of(LC_T1)];
            b1 = lst_size[slot_of(LC_B1)];
            t2 = lst_size[slot_of(LC_T2)];
            b2 = lst_size[slot_of(LC_B2)];
            if (t1 + b1 >= c) begin
                if (t1 < c) begin
                    v = list_pop_lru(LC_B1);
                    if (v >= 0) release_entry(v);
                    evict_to_ghost(0);
                end else begin
                    // T1 full: its LRU block is dropped without a ghost
                    v = list_pop_lru(LC_T1);
                    if (v >= 0) release_entry(v);
                end
            end else if (t1 + t2 + b1 + b2 >= c) begin
                if (t1 + t2 + b1 + b2 >= 2 * c) begin
                    v = list_pop_lru(LC_B2);
                    if (v >= 0) release_entry(v);
                end
                evict_to_ghost(0);
            end
            for (int i = 0; i < NENT; i++) begin
                if (dir_code[i] == LC_NONE) begin
                    e = i;
                    break;
                end
            end
            if (e >= 0) begin
                dir_blk[e] = blk;
                dir_dirty[e] = (rt == REQ_WRITE);
                list_push_mru(e, LC_T1);
            end
        end
        r.wb_v = wb_seen;
        r.wb_blk = wb_seen ? wb_addr : '0;
        r.tgt = target_p[CAP_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        mismatches++;
        $display("mismatch at %0t: %s got %0h expected %0h", $realtime, field, got, want);
    endtask

    // result checker
    always @(posedge i_clk) begin
        t_access_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected result class", 64'(o_access_class), 64'(0));
            end else begin
                want = pending_results.pop_front();
                if (o_access_class != want.cls)
                    report_mismatch("access_class", 64'(o_access_class), 64'(want.cls));
                if (o_needs_fetch != want.fetch)
                    report_mismatch("needs_fetch", 64'(o_needs_fetch), 64'(want.fetch));
                if (o_writeback_valid != want.wb_v)
                    report_mismatch("writeback_valid", 64'(o_writeback_valid),
                                    64'(want.wb_v));
                if (o_writeback_block != want.wb_blk)
                    report_mismatch("writeback_block", 64'(o_writeback_block),
                                    64'(want.wb_blk));
                if (o_target_p != want.tgt)
                    report_mismatch("target_p", 64'(o_target_p), 64'(want.tgt));
            end
        end
    end

    task automatic send_request(logic [BLK_W-1:0] blk, logic [1:0] rt);
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
        end
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_block_addr = blk;
        i_req_type = rt;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        pending_results.push_back(predict_access(blk, rt));
    endtask

    task automatic set_capacity(logic [CAP_W-1:0] v);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_cache_capacity = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        cap_reg = v;
        flush_directory();
    endtask

    function automatic logic [BLK_W-1:0] random_block();
        return BLK_W'({$urandom, $urandom});
    endfunction

    task automatic test_directed_default();
        send_request(48'h0, 2'd0);
        send_request(48'hFFFF_FFFF_FFFF, 2'd1);   // all-ones is an ordinary block
        send_request(48'h0, 2'd3);                // type three acts as read
        send_request(48'h0, 2'd1);                // write hit in T2
        send_request(48'hFFFF_FFFF_FFFF, 2'd2);
        send_request(48'hAAAA_5555_AAAA, 2'd2);
        send_request(48'h5555_AAAA_5555, 2'd1);
    endtask

    task automatic test_capacity_extremes();
        set_capacity(11'd0);                      // clamps to one block
        send_request(48'h10, 2'd1);
        send_request(48'h20, 2'd0);               // discards dirty 0x10 from T1
        send_request(48'h10, 2'd0);
        set_capacity(11'd2);
        send_request(48'h1, 2'd1);
        send_request(48'h1, 2'd0);
        send_request(48'h2, 2'd1);
        send_request(48'h3, 2'd0);                // 0x2 to B1 with writeback
        send_request(48'h2, 2'd0);                // ghost hit B1
        send_request(48'h4, 2'd1);
        send_request(48'h5, 2'd0);
        send_request(48'h1, 2'd2);
        send_request(48'h3, 2'd0);
        set_capacity(11'h7FF);                    // clamps to full capacity
        send_request(48'h123, 2'd1);
        send_request(48'h123, 2'd0);
    endtask

    task automatic run_random(int n, logic [CAP_W-1:0] c, int src_pct, int dst_pct);
        logic [BLK_W-1:0] blk;
        int c_eff;
        set_capacity(c);
        c_eff = (c == 0) ? 1 : ((c > CAP_MAX) ? CAP_MAX : int'(c));
        src_idle_pct = src_pct;
        dst_idle_pct = dst_pct;
        addr_pool.delete();
        for (int i = 0; i < 3 * c_eff + 2; i++) addr_pool.push_back(random_block());
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(19))
                0: blk = random_block();
                1: blk = '1;
                default: blk = addr_pool[$urandom_range(addr_pool.size() - 1)];
            endcase
            send_request(blk, 2'($urandom_range(3)));
        end
    endtask

    task automatic test_random_mix();
        int caps[8] = '{1, 2, 3, 5, 8, 16, 33, 64};
        for (int k = 0; k < 8; k++) begin
            run_random(65, 11'(caps[k]), 19, 79);
            run_random(65, 11'(caps[k]), 79, 19);
            run_random(65, 11'(caps[k]), 0, 0);
        end
        run_random(80, 11'd1024, 0, 0);
    endtask

    task automatic test_backpressure();
        set_capacity(11'd4);
        src_idle_pct = 0;
        dst_idle_pct = 0;
        hold_cycles = 400;
        for (int i = 0; i < 12; i++) send_request(48'(i % 6), 2'($urandom_range(3)));
        run_random(60, 11'd6, 0, 0);
    endtask

    initial begin
        mismatches = 0;
        hold_cycles = 0;
        src_idle_pct = 0;
        dst_idle_pct = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_cache_capacity = '0;
        i_in_valid = 1'b0;
        i_block_addr = '0;
        i_req_type = '0;
        cap_reg = CAP_MAX;
        flush_directory();
        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_default();
        test_capacity_extremes();
        test_random_mix();
        test_backpressure();

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
